// File: sv/cddr_pkg.sv
`timescale 1ns / 1ps
// cddr_pkg: shared types, constants and the label template for the dirty-run
// refresh core. No dependencies.

package cddr_pkg;

  // Fixed field widths of the words on both channels
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MAX_CHARS = 8;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam int unsigned       TEMPLATE_LEN = 80;

  // Command codes of the input word
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  // Power-up screen: four lines of twenty characters, first cell in the MSBs
  localparam logic [8*TEMPLATE_LEN-1:0] LABEL_TEMPLATE = {
    "K%:       Kom t:    ",
    "W%:       Zew t:    ",
    "                    ",
    "  :  :        .  .  "
  };

  // One chunk of a run, as loaded into the output register
  typedef struct packed {
    logic [IDX_W-1:0]                    first_cell;
    logic [CNT_W-1:0]                    count;
    logic [MAX_CHARS-1:0][CHAR_W-1:0]    chars;
    logic                                last;
  } chunk_t;

  // Reset content of one wanted cell; cells past the template are blank
  function automatic logic [CHAR_W-1:0] label_char(input logic [IDX_W-1:0] idx);
    int unsigned pos;
    pos = int'(idx);
    if (pos < TEMPLATE_LEN) begin
      return LABEL_TEMPLATE[8*(TEMPLATE_LEN-1-pos) +: 8];
    end
    return SPACE_CHAR;
  endfunction

endpackage

// File: sv/cddr_if.sv
`timescale 1ns / 1ps
// cddr_in_if / cddr_out_if: valid/ready channels of the refresh core.
// Depends on cddr_pkg.

interface cddr_in_if import cddr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IDX_W-1:0]  cell_index;
  logic [CHAR_W-1:0] char_code;
  logic              sink_ready;

  modport source (output valid, cmd, cell_index, char_code, sink_ready, input ready);
  modport sink   (input valid, cmd, cell_index, char_code, sink_ready, output ready);
endinterface

interface cddr_out_if import cddr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  first_cell;
  logic [CNT_W-1:0]  chunk_count;
  logic [CHAR_W-1:0] char_0;
  logic [CHAR_W-1:0] char_1;
  logic [CHAR_W-1:0] char_2;
  logic [CHAR_W-1:0] char_3;
  logic [CHAR_W-1:0] char_4;
  logic [CHAR_W-1:0] char_5;
  logic [CHAR_W-1:0] char_6;
  logic [CHAR_W-1:0] char_7;
  logic              last_of_run;

  modport source (output valid, first_cell, chunk_count, char_0, char_1, char_2, char_3,
                  char_4, char_5, char_6, char_7, last_of_run, input ready);
  modport sink   (input valid, first_cell, chunk_count, char_0, char_1, char_2, char_3,
                  char_4, char_5, char_6, char_7, last_of_run, output ready);
endinterface

// File: sv/cddr_ram.sv
`timescale 1ns / 1ps
// cddr_ram: one write port, one read port, registered read data.
// Holds the pending run. Depends on nothing.

module cddr_ram #(
  parameter int unsigned DEPTH = 80,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/cddr_screen.sv
`timescale 1ns / 1ps
// cddr_screen: wanted and shown screen memories, read together at one address.
// Valid bits stand in for the reset content. Depends on cddr_pkg.

module cddr_screen import cddr_pkg::*; #(
  parameter int unsigned CELLS = 80
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(CELLS)-1:0] rd_addr_i,
  input  logic                     w_we_i,
  input  logic [$clog2(CELLS)-1:0] w_addr_i,
  input  logic [CHAR_W-1:0]        w_data_i,
  input  logic                     s_we_i,
  input  logic [$clog2(CELLS)-1:0] s_addr_i,
  input  logic [CHAR_W-1:0]        s_data_i,
  output logic [CHAR_W-1:0]        w_rd_o,
  output logic [CHAR_W-1:0]        s_rd_o
);

  localparam int unsigned AW = $clog2(CELLS);

  logic [CHAR_W-1:0] wanted_mem [CELLS];
  logic [CHAR_W-1:0] shown_mem  [CELLS];
  logic [CELLS-1:0]  w_vld_q;
  logic [CELLS-1:0]  s_vld_q;

  logic [CHAR_W-1:0] w_mem_q;
  logic [CHAR_W-1:0] s_mem_q;
  logic              w_hit_q;
  logic              s_hit_q;
  logic [AW-1:0]     rd_addr_q;

  // memory arrays: writes and registered reads
  always_ff @(posedge clk_i) begin
    if (w_we_i) begin
      wanted_mem[w_addr_i] <= w_data_i;
    end
    if (s_we_i) begin
      shown_mem[s_addr_i] <= s_data_i;
    end
    w_mem_q   <= wanted_mem[rd_addr_i];
    s_mem_q   <= shown_mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  // valid bits: an entry never written reads as its reset content
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= '0;
      s_vld_q <= '0;
      w_hit_q <= 1'b0;
      s_hit_q <= 1'b0;
    end else begin
      if (w_we_i) begin
        w_vld_q[w_addr_i] <= 1'b1;
      end
      if (s_we_i) begin
        s_vld_q[s_addr_i] <= 1'b1;
      end
      w_hit_q <= w_vld_q[rd_addr_i];
      s_hit_q <= s_vld_q[rd_addr_i];
    end
  end

  assign w_rd_o = w_hit_q ? w_mem_q : label_char(IDX_W'(rd_addr_q));
  assign s_rd_o = s_hit_q ? s_mem_q : SPACE_CHAR;

endmodule

// File: sv/cddr_out_stage.sv
`timescale 1ns / 1ps
// cddr_out_stage: output register for one chunk word, frees the core to go on.
// Depends on cddr_pkg and cddr_out_if.

module cddr_out_stage import cddr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  chunk_t         chunk_i,
  output logic           free_o,
  cddr_out_if.source     out_o
);

  logic   valid_q;
  chunk_t chunk_q;

  assign free_o = !valid_q || out_o.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // payload, held until taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chunk_q <= chunk_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.first_cell  = chunk_q.first_cell;
  assign out_o.chunk_count = chunk_q.count;
  assign out_o.char_0      = chunk_q.chars[0];
  assign out_o.char_1      = chunk_q.chars[1];
  assign out_o.char_2      = chunk_q.chars[2];
  assign out_o.char_3      = chunk_q.chars[3];
  assign out_o.char_4      = chunk_q.chars[4];
  assign out_o.char_5      = chunk_q.chars[5];
  assign out_o.char_6      = chunk_q.chars[6];
  assign out_o.char_7      = chunk_q.chars[7];
  assign out_o.last_of_run = chunk_q.last;

endmodule

// File: sv/char_display_dirty_run_refresh_core.sv
`timescale 1ns / 1ps
// char_display_dirty_run_refresh_core: top level, scan/emit sequencer.
// Depends on cddr_pkg, cddr_if, cddr_ram, cddr_screen, cddr_out_stage.
//
//  channel | dir | word                                           | accepted when
//  in_i    | in  | cmd, cell_index, char_code, sink_ready         | valid & ready
//  out_o   | out | first_cell, chunk_count, char_0..7, last_of_run | valid & ready
//
// A poll takes the word, then compares cells one by one from the scan pointer up to
// and including the cell after the run (the end of the screen counts as one such
// cell); a poll that finds no difference ends the same way with no chunk. With
// sink_ready low the run is kept and offered again by a later poll. Each chunk
// then goes through pending reads, shown write-back and hand-off, plus any wait
// for the output register; the memories give one read per cycle.
// Reset is immediate: valid bits give the label template and blank shown screen.
// in_i is taken only while the sequencer is idle: a chunk waiting for a busy output register
// holds the sequencer and so the input; the last chunk left in it does not.

module char_display_dirty_run_refresh_core import cddr_pkg::*; #(
  parameter int unsigned CELLS            = 80,
  parameter int unsigned CHARS_PER_RESULT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cddr_in_if.sink    in_i,
  cddr_out_if.source out_o
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned PW = $clog2(CELLS + 1);
  localparam int unsigned KW = $clog2(CHARS_PER_RESULT + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_SEND = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_RUN,
    ST_LOAD,
    ST_PUSH
  } state_e;

  state_e  st_q, st_d;
  phase_e  phase_q, phase_d;
  logic    rdy_q, rdy_d;
  logic [PW-1:0] scan_ptr_q, scan_ptr_d;
  logic [PW-1:0] iss_q, iss_d;
  logic [AW-1:0] cmp_q, cmp_d;
  logic          dv_q, dv_d;
  logic [AW-1:0] run_start_q, run_start_d;
  logic [PW-1:0] run_len_q, run_len_d;
  logic [PW-1:0] done_q, done_d;
  logic [KW-1:0] ki_q, ki_d;
  logic [KW-1:0] kd_q, kd_d;
  logic          pdv_q, pdv_d;
  logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_q, chars_d;

  logic [AW-1:0]     scr_raddr;
  logic              w_we, s_we, p_we;
  logic [AW-1:0]     p_waddr, p_raddr, s_waddr;
  logic [CHAR_W-1:0] w_rd, s_rd, p_rd;
  logic              out_load, out_free;
  chunk_t            chunk;
  logic [PW-1:0]     start_ptr, rem, done_nxt;
  logic [KW-1:0]     n_w;
  logic              diff;

  // memories
  cddr_screen #(.CELLS(CELLS)) u_screen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (scr_raddr),
    .w_we_i    (w_we),
    .w_addr_i  (AW'(in_i.cell_index)),
    .w_data_i  (in_i.char_code),
    .s_we_i    (s_we),
    .s_addr_i  (s_waddr),
    .s_data_i  (p_rd),
    .w_rd_o    (w_rd),
    .s_rd_o    (s_rd)
  );

  cddr_ram #(.DEPTH(CELLS), .WIDTH(CHAR_W)) u_pend (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (w_rd),
    .raddr_i (p_raddr),
    .rdata_o (p_rd)
  );

  cddr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .chunk_i (chunk),
    .free_o  (out_free),
    .out_o   (out_o)
  );

  assign in_i.ready = (st_q == ST_IDLE);

  // chunk size and addresses inside the current run
  assign rem      = run_len_q - done_q;
  assign n_w      = (32'(rem) > CHARS_PER_RESULT) ? KW'(CHARS_PER_RESULT) : KW'(rem);
  assign done_nxt = done_q + PW'(n_w);
  assign diff     = (w_rd != s_rd);
  assign p_raddr  = AW'(done_q + PW'(ki_q));
  assign s_waddr  = AW'(PW'(run_start_q) + done_q + PW'(kd_q));
  assign start_ptr = (phase_q == PH_SCAN) ? scan_ptr_q : '0;

  assign chunk.first_cell = IDX_W'(PW'(run_start_q) + done_q);
  assign chunk.count      = CNT_W'(n_w);
  assign chunk.chars      = chars_q;
  assign chunk.last       = (done_nxt >= run_len_q);

  // sequencer
  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    rdy_d       = rdy_q;
    scan_ptr_d  = scan_ptr_q;
    iss_d       = iss_q;
    cmp_d       = cmp_q;
    dv_d        = dv_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    done_d      = done_q;
    ki_d        = ki_q;
    kd_d        = kd_q;
    pdv_d       = pdv_q;
    chars_d     = chars_q;
    scr_raddr   = AW'(iss_q);
    w_we        = 1'b0;
    s_we        = 1'b0;
    p_we        = 1'b0;
    p_waddr     = AW'(run_len_q);
    out_load    = 1'b0;

    // screen read issue, one cell a cycle while scanning
    if (st_q == ST_SKIP || st_q == ST_RUN) begin
      if (32'(iss_q) < CELLS) begin
        iss_d = iss_q + 1'b1;
        cmp_d = AW'(iss_q);
        dv_d  = 1'b1;
      end else begin
        dv_d  = 1'b0;
      end
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.cmd == CMD_WRITE) begin
            w_we = (32'(in_i.cell_index) < CELLS);
          end else begin
            rdy_d = in_i.sink_ready;
            if (phase_q == PH_SEND) begin
              // run already captured: offer it again
              if (in_i.sink_ready) begin
                done_d  = '0;
                ki_d    = '0;
                pdv_d   = 1'b0;
                chars_d = '0;
                st_d    = ST_LOAD;
              end
            end else begin
              phase_d   = PH_SCAN;
              scr_raddr = AW'(start_ptr);
              if (32'(start_ptr) < CELLS) begin
                iss_d = start_ptr + 1'b1;
                cmp_d = AW'(start_ptr);
                dv_d  = 1'b1;
              end else begin
                dv_d  = 1'b0;
              end
              st_d = ST_SKIP;
            end
          end
        end
      end

      ST_SKIP: begin
        if (dv_q && diff) begin
          run_start_d = cmp_q;
          p_we        = 1'b1;
          p_waddr     = '0;
          run_len_d   = PW'(1);
          st_d        = ST_RUN;
        end else if (!dv_q) begin
          // nothing left to refresh
          phase_d = PH_IDLE;
          st_d    = ST_IDLE;
        end
      end

      ST_RUN: begin
        if (dv_q && diff) begin
          p_we      = 1'b1;
          run_len_d = run_len_q + 1'b1;
        end else begin
          scan_ptr_d = dv_q ? PW'(cmp_q) : PW'(CELLS);
          phase_d    = PH_SEND;
          if (rdy_q) begin
            done_d  = '0;
            ki_d    = '0;
            pdv_d   = 1'b0;
            chars_d = '0;
            st_d    = ST_LOAD;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end

      ST_LOAD: begin
        // read pending entries, shown store takes each as it arrives
        if (ki_q < n_w) begin
          ki_d  = ki_q + 1'b1;
          kd_d  = ki_q;
          pdv_d = 1'b1;
        end else begin
          pdv_d = 1'b0;
        end
        if (pdv_q) begin
          s_we = 1'b1;
          for (int j = 0; j < CHARS_PER_RESULT; j++) begin
            if (kd_q == KW'(j)) begin
              chars_d[j] = p_rd;
            end
          end
        end else if (ki_q == n_w) begin
          st_d = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          done_d   = done_nxt;
          if (done_nxt >= run_len_q) begin
            phase_d = PH_SCAN;
            st_d    = ST_IDLE;
          end else begin
            ki_d    = '0;
            pdv_d   = 1'b0;
            chars_d = '0;
            st_d    = ST_LOAD;
          end
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // state and run registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_IDLE;
      rdy_q       <= 1'b0;
      scan_ptr_q  <= '0;
      iss_q       <= '0;
      cmp_q       <= '0;
      dv_q        <= 1'b0;
      run_start_q <= '0;
      run_len_q   <= '0;
      done_q      <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      pdv_q       <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      rdy_q       <= rdy_d;
      scan_ptr_q  <= scan_ptr_d;
      iss_q       <= iss_d;
      cmp_q       <= cmp_d;
      dv_q        <= dv_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      done_q      <= done_d;
      ki_q        <= ki_d;
      kd_q        <= kd_d;
      pdv_q       <= pdv_d;
    end
  end

  // chunk assembly buffer
  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

// File: sv/cddr_checker.sv
`timescale 1ns / 1ps
// cddr_checker: port-level assertions on the refresh core, bound to the top.
// Depends on cddr_pkg and char_display_dirty_run_refresh_core.

module cddr_checker import cddr_pkg::*; #(
  parameter int unsigned CELLS            = 80,
  parameter int unsigned CHARS_PER_RESULT = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] first_cell,
  input logic [3:0] chunk_count,
  input logic [7:0] char_7,
  input logic       last_of_run
);

  // chunk length within bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (chunk_count != 4'd0) && (32'(chunk_count) <= CHARS_PER_RESULT))
    else $error("chunk_count out of range");

  // chunk lies inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (32'(first_cell) + 32'(chunk_count) <= CELLS))
    else $error("chunk runs past last cell");

  // unused trailing character is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (chunk_count < 4'd8) |-> (char_7 == 8'd0))
    else $error("unused character not cleared");

  // a write word never starts a chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_cmd == CMD_WRITE) && !out_valid |=> !out_valid)
    else $error("output after a write word");

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(first_cell) && $stable(last_of_run))
    else $error("stalled word changed");

endmodule

bind char_display_dirty_run_refresh_core cddr_checker #(
  .CELLS            (CELLS),
  .CHARS_PER_RESULT (CHARS_PER_RESULT)
) u_cddr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_cmd      (in_i.cmd),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .first_cell  (out_o.first_cell),
  .chunk_count (out_o.chunk_count),
  .char_7      (out_o.char_7),
  .last_of_run (out_o.last_of_run)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for char_display_dirty_run_refresh_core.
// Depends on cddr_pkg, cddr_in_if / cddr_out_if and the core itself.

module tb;
  import cddr_pkg::*;

  localparam int unsigned CELLS        = 80;
  localparam int unsigned CHUNK_CHARS  = 8;
  localparam int unsigned ITEMS        = 500;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_SEND = 2'd2
  } scan_phase_e;

  // Screen predictor plus the queue of chunks still owed by the core
  class screen_model;
    logic [CHAR_W-1:0] wanted    [CELLS];
    logic [CHAR_W-1:0] shown     [CELLS];
    logic [CHAR_W-1:0] run_chars [CELLS];
    scan_phase_e       phase;
    int unsigned       scan_ptr;
    int unsigned       run_first;
    int unsigned       run_len;
    chunk_t            expected_chunks[$];
    int unsigned       errors;

    function new();
      for (int i = 0; i < CELLS; i++) begin
        wanted[i]    = (i < TEMPLATE_LEN) ? LABEL_TEMPLATE[8*(TEMPLATE_LEN-1-i) +: 8]
                                          : SPACE_CHAR;
        shown[i]     = SPACE_CHAR;
        run_chars[i] = '0;
      end
      phase     = PH_IDLE;
      scan_ptr  = 0;
      run_first = 0;
      run_len   = 0;
      errors    = 0;
    endfunction

    // Accepted input word: update the screen and queue any chunks it causes
    function void apply_word(logic cmd, logic [IDX_W-1:0] idx, logic [CHAR_W-1:0] code,
                             logic rdy);
      chunk_t      c;
      int unsigned done;
      int unsigned n;
      if (cmd == CMD_WRITE) begin
        if (idx < CELLS) wanted[idx] = code;
        return;
      end
      if (phase != PH_SCAN && phase != PH_SEND) begin
        scan_ptr = 0;
        phase    = PH_SCAN;
      end
      // look for the next differing run and latch it
      if (phase == PH_SCAN) begin
        while (scan_ptr < CELLS && wanted[scan_ptr] == shown[scan_ptr]) scan_ptr++;
        if (scan_ptr >= CELLS) begin
          phase = PH_IDLE;
          return;
        end
        run_first = scan_ptr;
        run_len   = 0;
        while (scan_ptr < CELLS && wanted[scan_ptr] != shown[scan_ptr]) begin
          run_chars[run_len] = wanted[scan_ptr];
          run_len++;
          scan_ptr++;
        end
        phase = PH_SEND;
      end
      if (!rdy) return;
      phase = PH_SCAN;
      // split the latched run into chunks
      done = 0;
      while (done < run_len) begin
        n = run_len - done;
        if (n > CHUNK_CHARS) n = CHUNK_CHARS;
        c            = '0;
        c.first_cell = IDX_W'(run_first + done);
        c.count      = CNT_W'(n);
        for (int k = 0; k < n; k++) c.chars[k] = run_chars[done + k];
        done += n;
        c.last = (done >= run_len);
        expected_chunks.push_back(c);
      end
      for (int i = 0; i < run_len; i++) shown[run_first + i] = run_chars[i];
    endfunction

    // Accepted output word against the oldest expectation
    function void check_chunk(chunk_t got);
      chunk_t want;
      if (expected_chunks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected chunk: cell=%0d n=%0d chars=%h last=%b",
                   got.first_cell, got.count, got.chars, got.last);
        return;
      end
      want = expected_chunks.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"chunk mismatch: exp cell=%0d n=%0d chars=%h last=%b",
                    " / got cell=%0d n=%0d chars=%h last=%b"},
                   want.first_cell, want.count, want.chars, want.last,
                   got.first_cell, got.count, got.chars, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          no_idle;
  bit          hold_req;
  int unsigned words_sent;
  int unsigned cycle_cnt;
  screen_model sb;

  cddr_in_if  in_bus ();
  cddr_out_if out_bus ();

  char_display_dirty_run_refresh_core #(
    .CELLS            (CELLS),
    .CHARS_PER_RESULT (CHUNK_CHARS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[char_display_dirty_run_refresh_core] ERROR");
    $finish;
  end

  // Monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    chunk_t got;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got.first_cell = out_bus.first_cell;
        got.count      = out_bus.chunk_count;
        got.chars[0]   = out_bus.char_0;
        got.chars[1]   = out_bus.char_1;
        got.chars[2]   = out_bus.char_2;
        got.chars[3]   = out_bus.char_3;
        got.chars[4]   = out_bus.char_4;
        got.chars[5]   = out_bus.char_5;
        got.chars[6]   = out_bus.char_6;
        got.chars[7]   = out_bus.char_7;
        got.last       = out_bus.last_of_run;
        sb.check_chunk(got);
      end
      if (in_bus.valid && in_bus.ready)
        sb.apply_word(in_bus.cmd, in_bus.cell_index, in_bus.char_code, in_bus.sink_ready);
    end
  end

  // Receiver: random stalls per word, plus one long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned hold_cnt;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(negedge clk_i);
          hold_cnt++;
        end
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
      @(negedge clk_i);
    end
  end

  // Offer one input word after a random gap; returns on the falling edge after acceptance
  task automatic send_word(logic cmd, logic [IDX_W-1:0] idx, logic [CHAR_W-1:0] code,
                           logic rdy);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= cmd;
    in_bus.cell_index <= idx;
    in_bus.char_code  <= code;
    in_bus.sink_ready <= rdy;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    words_sent++;
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned kind;
    int unsigned start;
    int unsigned len;
    sb                = new();
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    words_sent        = 0;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.cmd        = CMD_WRITE;
    in_bus.cell_index = '0;
    in_bus.char_code  = '0;
    in_bus.sink_ready = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: busy sink keeps the latched run, out-of-range writes, long run
    send_word(CMD_POLL, 7'd0, 8'd0, 1'b0);
    send_word(CMD_WRITE, 7'd1, 8'h00, 1'b1);
    send_word(CMD_POLL, 7'd127, 8'hFF, 1'b0);
    send_word(CMD_POLL, 7'd0, 8'h00, 1'b1);
    send_word(CMD_WRITE, 7'd80, 8'hFF, 1'b0);
    send_word(CMD_WRITE, 7'd127, 8'h55, 1'b1);
    send_word(CMD_WRITE, 7'd79, 8'hFF, 1'b0);
    send_word(CMD_WRITE, 7'd0, 8'h00, 1'b0);
    send_word(CMD_POLL, 7'd0, 8'h00, 1'b1);
    for (int i = 0; i < 12; i++)
      send_word(CMD_WRITE, IDX_W'(40 + i), CHAR_W'(8'h41 + i), 1'b0);
    repeat (4) send_word(CMD_POLL, 7'd0, 8'd0, 1'b1);

    // receiver goes quiet after its next word while traffic continues
    hold_req = 1'b1;

    // random: mostly write bursts followed by polls, some full-screen
    // rewrites, the rest bare polls and stray writes
    while (words_sent < ITEMS) begin
      no_idle = ($urandom_range(0, 9) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 4) begin
        for (int i = 0; i < CELLS; i++)
          send_word(CMD_WRITE, IDX_W'(i), sb.shown[i] ^ CHAR_W'($urandom_range(1, 255)),
                    1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 3))
          send_word(CMD_POLL, IDX_W'($urandom), CHAR_W'($urandom), 1'b1);
      end else if (kind < 60) begin
        start = $urandom_range(0, CELLS - 1);
        len   = $urandom_range(1, 20);
        for (int i = start; i < start + len && i < CELLS; i++)
          send_word(CMD_WRITE, IDX_W'(i), CHAR_W'($urandom), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4))
          send_word(CMD_POLL, IDX_W'($urandom), CHAR_W'($urandom),
                    ($urandom_range(0, 3) != 0));
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6))
          send_word(CMD_POLL, IDX_W'($urandom), CHAR_W'($urandom),
                    1'($urandom_range(0, 1)));
      end else begin
        send_word(CMD_WRITE, IDX_W'($urandom_range(0, 127)), CHAR_W'($urandom),
                  1'($urandom_range(0, 1)));
      end
    end
    in_bus.valid <= 1'b0;

    // drain
    while (sb.expected_chunks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_chunks.size() == 0) begin
      $display("[char_display_dirty_run_refresh_core] OK");
    end else begin
      $display("[char_display_dirty_run_refresh_core] ERROR");
    end
    $finish;
  end

endmodule
